// ===== hdl/stereo_feedback_comb_mixer_macros.svh =====
// Assertion macros shared by the mixer RTL.
`ifndef STEREO_FEEDBACK_COMB_MIXER_MACROS_SVH
`define STEREO_FEEDBACK_COMB_MIXER_MACROS_SVH
`ifndef SYNTHESIS
`define SFCM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfcm: same-cycle check failed");
`define SFCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfcm: next-cycle check failed");
`else
`define SFCM_ASSERT_SAME(label, clk, rst, ante, cons)
`define SFCM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/sfcm_pkg.sv =====
package sfcm_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS   = SAMPLE_BITS - 5;
   localparam int RING_DEPTH  = 16;
   localparam int POS_BITS    = $clog2(RING_DEPTH);
   localparam int CNT_BITS    = 6;

   // Coefficients are unsigned Q.16.
   localparam int COEF_BITS   = 17;
   localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS + 1;
   localparam int SCALED_BITS = PROD_BITS - 16;
   localparam int SUM_BITS    = SCALED_BITS + 2;

   localparam logic [COEF_BITS-1:0] K_FEEDBACK = 17'd36045;
   localparam logic [COEF_BITS-1:0] K_DRY      = 17'd47186;
   localparam logic [COEF_BITS-1:0] K_WET      = 17'd26214;
   localparam logic [COEF_BITS-1:0] K_LOW      = 17'd5243;
   localparam logic [COEF_BITS-1:0] K_HIGH     = 17'd117965;

   localparam logic [1:0] MODE_PASS   = 2'd0;
   localparam logic [1:0] MODE_WOBBLE = 2'd1;
   localparam logic [1:0] MODE_COMB   = 2'd2;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ARM        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_USE_BUFFER = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DESC_BASE  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DESC_END   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DESC_SPAN  = 3'd4;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic       block_start;
      sample_type dry_left;
      sample_type dry_right;
      sample_type bus_left;
      sample_type bus_right;
   } req_type;

   typedef struct packed {
      sample_type out_left;
      sample_type out_right;
      logic [1:0] mode_taken;
   } rsp_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       swap_gains;
   } core_ctl_type;

endpackage

// ===== hdl/sfcm_core.sv =====
module sfcm_core (
   input  sfcm_pkg::req_type      item,
   input  sfcm_pkg::core_ctl_type ctl,
   input  sfcm_pkg::sample_type   ring_rd,
   output sfcm_pkg::rsp_type      result,
   output sfcm_pkg::sample_type   ring_in
);
   import sfcm_pkg::*;

   localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(32768);
   localparam logic signed [SCALED_BITS-1:0] LIM_ZERO = SCALED_BITS'(4 * (2 ** FRAC_BITS));
   localparam logic signed [SCALED_BITS-1:0] LIM_ZERO_NEG = -LIM_ZERO;
   localparam logic signed [SCALED_BITS-1:0] LIM_CLAMP =
      SCALED_BITS'(3 * (2 ** (FRAC_BITS - 1)));
   localparam logic signed [SCALED_BITS-1:0] LIM_CLAMP_NEG = -LIM_CLAMP;
   localparam logic signed [SUM_BITS-1:0] SAT_MAX = SUM_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SUM_BITS-1:0] SAT_MIN = ~SAT_MAX;

   // Product rounded to nearest, ties toward positive infinity.
   function automatic logic signed [SCALED_BITS-1:0] mulq(input sample_type x,
                                                           input logic [COEF_BITS-1:0] k);
      logic signed [PROD_BITS-1:0] p;
      p = PROD_BITS'(x) * $signed({1'b0, k}) + ROUND_HALF;
      mulq = p[PROD_BITS-1:16];
   endfunction

   function automatic sample_type limit(input logic signed [SCALED_BITS-1:0] v);
      logic signed [SCALED_BITS-1:0] z;
      if (v >= LIM_ZERO || v <= LIM_ZERO_NEG) begin
         z = '0;
      end else begin
         z = v;
      end
      if (z > LIM_CLAMP) begin
         z = LIM_CLAMP;
      end else if (z < LIM_CLAMP_NEG) begin
         z = LIM_CLAMP_NEG;
      end
      limit = z[SAMPLE_BITS-1:0];
   endfunction

   function automatic sample_type sat(input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] z;
      if (v > SAT_MAX) begin
         z = SAT_MAX;
      end else if (v < SAT_MIN) begin
         z = SAT_MIN;
      end else begin
         z = v;
      end
      sat = z[SAMPLE_BITS-1:0];
   endfunction

   logic                          is_comb;
   logic                          is_pass;
   logic [COEF_BITS-1:0]          gain_left;
   logic [COEF_BITS-1:0]          gain_right;
   logic signed [SAMPLE_BITS:0]   mono_sum;
   sample_type                    mono;
   sample_type                    delayed;
   logic signed [SCALED_BITS-1:0] store_pre;
   logic signed [SCALED_BITS-1:0] wet;
   logic signed [SCALED_BITS-1:0] scaled_left;
   logic signed [SCALED_BITS-1:0] scaled_right;
   logic signed [SUM_BITS-1:0]    add_left;
   logic signed [SUM_BITS-1:0]    add_right;
   logic signed [SUM_BITS-1:0]    wet_term;
   logic signed [SUM_BITS-1:0]    sum_left;
   logic signed [SUM_BITS-1:0]    sum_right;

   assign is_comb = (ctl.mode == MODE_COMB);
   assign is_pass = (ctl.mode == MODE_PASS);

   // The dry multiplier is shared between the wobble gains and the comb dry gain.
   assign gain_left  = is_comb ? K_DRY : (ctl.swap_gains ? K_LOW : K_HIGH);
   assign gain_right = is_comb ? K_DRY : (ctl.swap_gains ? K_HIGH : K_LOW);

   assign mono_sum = (SAMPLE_BITS+1)'(item.dry_left) + (SAMPLE_BITS+1)'(item.dry_right);
   assign mono     = mono_sum[SAMPLE_BITS:1];

   assign delayed   = limit(SCALED_BITS'(ring_rd));
   assign store_pre = SCALED_BITS'(mono) + mulq(delayed, K_FEEDBACK);
   assign ring_in   = limit(store_pre);
   assign wet       = mulq(delayed, K_WET);

   assign scaled_left  = mulq(item.dry_left, gain_left);
   assign scaled_right = mulq(item.dry_right, gain_right);

   assign add_left  = is_pass ? SUM_BITS'(item.dry_left) : SUM_BITS'(scaled_left);
   assign add_right = is_pass ? SUM_BITS'(item.dry_right) : SUM_BITS'(scaled_right);
   assign wet_term  = is_comb ? SUM_BITS'(wet) : '0;

   assign sum_left  = SUM_BITS'(item.bus_left) + add_left + wet_term;
   assign sum_right = SUM_BITS'(item.bus_right) + add_right + wet_term;

   assign result.out_left   = sat(sum_left);
   assign result.out_right  = sat(sum_right);
   assign result.mode_taken = ctl.mode;

endmodule

// ===== hdl/stereo_feedback_comb_mixer.sv =====
// Stereo feedback comb mixer. Takes one item per clock, back to back, while
// the output is not stalled, and returns one result item per input item, in
// order. The result register is loaded from the input register when the
// output advances. While a result waits in the output register, the input
// register can still take one item, and after that the input stalls. The
// rate of one item per cycle while not stalled is set by the read-modify-write
// of the 16-entry comb ring, which is held in flip-flops and cleared by reset
// with no clearing pass. Configuration registers are to be written by the user
// only while the block is idle; the block itself does not enforce it. The
// descriptor plausibility flag is registered from the descriptor registers.
`include "stereo_feedback_comb_mixer_macros.svh"

module stereo_feedback_comb_mixer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sfcm_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sfcm_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write,
   input  logic [sfcm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sfcm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import sfcm_pkg::*;

   localparam logic [CSR_DATA_BITS-1:0] DESC_MIN_BYTES  = 32'd96;
   localparam logic [CSR_DATA_BITS-1:0] DESC_MAX_BYTES  = 32'h0080_0000;
   localparam logic [CSR_DATA_BITS-1:0] DESC_ALIGN_MASK = 32'd3;

   logic                     arm_ff, arm_in;
   logic                     use_buffer_ff, use_buffer_in;
   logic [CSR_DATA_BITS-1:0] desc_base_ff, desc_base_in;
   logic [CSR_DATA_BITS-1:0] desc_end_ff, desc_end_in;
   logic [CSR_DATA_BITS-1:0] desc_span_ff, desc_span_in;
   logic                     plaus_ff, plaus_in;
   logic [CSR_DATA_BITS-1:0] desc_bytes;

   logic                     in_valid_ff, in_valid_in;
   req_type                  in_data_ff, in_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   sample_type               ring_ff [RING_DEPTH];
   logic [POS_BITS-1:0]      ring_pos_ff, ring_pos_in;
   logic [CNT_BITS-1:0]      block_cnt_ff, block_cnt_in;
   logic [CNT_BITS-1:0]      cnt_next;

   logic                     advance;
   logic                     fire;
   logic [1:0]               mode;
   core_ctl_type             core_ctl;
   rsp_type                  core_result;
   sample_type               ring_in;

   // Configuration registers.
   always_comb begin
      arm_in        = arm_ff;
      use_buffer_in = use_buffer_ff;
      desc_base_in  = desc_base_ff;
      desc_end_in   = desc_end_ff;
      desc_span_in  = desc_span_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ARM:        arm_in        = csr_wdata[0];
            CSR_USE_BUFFER: use_buffer_in = csr_wdata[0];
            CSR_DESC_BASE:  desc_base_in  = csr_wdata;
            CSR_DESC_END:   desc_end_in   = csr_wdata;
            CSR_DESC_SPAN:  desc_span_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   assign desc_bytes = desc_end_ff - desc_base_ff;

   always_comb begin
      plaus_in = (desc_base_ff != '0)
              && (desc_end_ff > desc_base_ff)
              && (((desc_base_ff | desc_end_ff | desc_span_ff) & DESC_ALIGN_MASK) == '0)
              && (desc_bytes >= DESC_MIN_BYTES) && (desc_span_ff >= DESC_MIN_BYTES)
              && (desc_bytes <= DESC_MAX_BYTES) && (desc_span_ff <= DESC_MAX_BYTES)
              && (desc_span_ff >= desc_bytes);
   end

   // Two-register pipeline: the input register feeds the result register.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end else begin
         in_valid_in = in_valid_ff;
         in_data_in  = in_data_ff;
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
      rsp_data_in  = fire ? core_result : rsp_data_ff;
   end

   always_comb begin
      if (!arm_ff || !plaus_ff) begin
         mode = MODE_PASS;
      end else if (!use_buffer_ff) begin
         mode = MODE_WOBBLE;
      end else begin
         mode = MODE_COMB;
      end
   end

   // The wobble counter steps before its top bit picks the gains.
   assign cnt_next = block_cnt_ff + CNT_BITS'(in_data_ff.block_start);

   assign core_ctl.mode       = mode;
   assign core_ctl.swap_gains = cnt_next[CNT_BITS-1];

   always_comb begin
      block_cnt_in = block_cnt_ff;
      ring_pos_in  = ring_pos_ff;
      if (fire && mode == MODE_WOBBLE) begin
         block_cnt_in = cnt_next;
      end
      if (fire && mode == MODE_COMB) begin
         ring_pos_in = (ring_pos_ff == POS_BITS'(RING_DEPTH - 1)) ? '0
                                                                : ring_pos_ff + POS_BITS'(1);
      end
   end

   sfcm_core u_core (
      .item    (in_data_ff),
      .ctl     (core_ctl),
      .ring_rd (ring_ff[ring_pos_ff]),
      .result  (core_result),
      .ring_in (ring_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_ff        <= 1'b0;
         use_buffer_ff <= 1'b0;
         desc_base_ff  <= '0;
         desc_end_ff   <= '0;
         desc_span_ff  <= '0;
         plaus_ff      <= 1'b0;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ring_pos_ff   <= '0;
         block_cnt_ff  <= '0;
      end else begin
         arm_ff        <= arm_in;
         use_buffer_ff <= use_buffer_in;
         desc_base_ff  <= desc_base_in;
         desc_end_ff   <= desc_end_in;
         desc_span_ff  <= desc_span_in;
         plaus_ff      <= plaus_in;
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         ring_pos_ff   <= ring_pos_in;
         block_cnt_ff  <= block_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (fire && mode == MODE_COMB) begin
         ring_ff[ring_pos_ff] <= ring_in;
      end
   end

   `SFCM_ASSERT_NEXT(a_rsp_loaded, clock, reset, fire, rsp_valid_ff)
   `SFCM_ASSERT_NEXT(a_pass_off, clock, reset, fire && !arm_ff, rsp_data.mode_taken == MODE_PASS)
   `SFCM_ASSERT_NEXT(a_pos_hold, clock, reset, !(fire && mode == MODE_COMB), $stable(ring_pos_ff))
   `SFCM_ASSERT_NEXT(a_cnt_hold, clock, reset, !(fire && mode == MODE_WOBBLE), $stable(block_cnt_ff))

endmodule

// ===== verif/tb_stereo_feedback_comb_mixer.sv =====
`timescale 1ns / 100ps

module tb_stereo_feedback_comb_mixer;
   import sfcm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 600;
   localparam int LONG_HOLD      = 300;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   localparam longint BUS_MAX    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint BUS_MIN    = -(longint'(1) << (SAMPLE_BITS - 1));
   localparam longint ZERO_LEVEL = longint'(4) << FRAC_BITS;
   localparam longint CLAMP_LEVEL = longint'(3) << (FRAC_BITS - 1);
   localparam longint ROUND_HALF = longint'(1) << 15;

   localparam logic [31:0] DESC_MIN_BYTES = 32'd96;
   localparam logic [31:0] DESC_MAX_BYTES = 32'h0080_0000;
   localparam logic [31:0] DESC_ALIGN     = 32'd3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_ARM;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   rsp_type expected_mix_q[$];
   int      mismatch_count = 0;

   // Sender and receiver idling controls.
   int          burst_left = 0;
   int          gap_level = 1;
   int          stall_level = 1;
   int          hold_request = 0;
   int          hold_left = 0;
   int          pat_step = 0;
   logic [31:0] stall_pat = '0;

   // Shadow of the mixer state and its registers.
   sample_type          ring_mem [RING_DEPTH];
   logic [POS_BITS-1:0] ring_pos;
   logic [CNT_BITS-1:0] block_cnt;
   logic                arm_reg;
   logic                buf_reg;
   logic [31:0]         base_reg;
   logic [31:0]         end_reg;
   logic [31:0]         span_reg;

   stereo_feedback_comb_mixer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint scale_q16(longint x, longint k);
      return (x * k + ROUND_HALF) >>> 16;
   endfunction

   function automatic sample_type saturate_bus(longint v);
      if (v > BUS_MAX) return SAMPLE_MAX;
      if (v < BUS_MIN) return SAMPLE_MIN;
      return sample_type'(v);
   endfunction

   function automatic longint limit_ring(longint v);
      if (v >= ZERO_LEVEL || v <= -ZERO_LEVEL) v = 0;
      if (v > CLAMP_LEVEL) v = CLAMP_LEVEL;
      if (v < -CLAMP_LEVEL) v = -CLAMP_LEVEL;
      return v;
   endfunction

   function automatic bit descriptor_ok();
      logic [31:0] bytes;
      bytes = end_reg - base_reg;
      if (base_reg == '0 || end_reg <= base_reg) return 1'b0;
      if (((base_reg | end_reg | span_reg) & DESC_ALIGN) != '0) return 1'b0;
      if (bytes < DESC_MIN_BYTES || span_reg < DESC_MIN_BYTES) return 1'b0;
      if (bytes > DESC_MAX_BYTES || span_reg > DESC_MAX_BYTES) return 1'b0;
      return span_reg >= bytes;
   endfunction

   // Works out the new bus values for one item and advances the shadow state.
   function automatic rsp_type mix_sample(req_type item);
      rsp_type r;
      longint  dl, dr, bl, br, gl, gr, delayed, stored, wet;
      dl = item.dry_left;
      dr = item.dry_right;
      bl = item.bus_left;
      br = item.bus_right;
      if (!arm_reg || !descriptor_ok()) begin
         r.out_left   = saturate_bus(bl + dl);
         r.out_right  = saturate_bus(br + dr);
         r.mode_taken = MODE_PASS;
      end else if (!buf_reg) begin
         if (item.block_start) block_cnt = block_cnt + 1'b1;
         gl = block_cnt[CNT_BITS-1] ? K_LOW : K_HIGH;
         gr = block_cnt[CNT_BITS-1] ? K_HIGH : K_LOW;
         r.out_left   = saturate_bus(bl + scale_q16(dl, gl));
         r.out_right  = saturate_bus(br + scale_q16(dr, gr));
         r.mode_taken = MODE_WOBBLE;
      end else begin
         delayed = limit_ring(ring_mem[ring_pos]);
         stored  = limit_ring(((dl + dr) >>> 1) + scale_q16(delayed, K_FEEDBACK));
         ring_mem[ring_pos] = sample_type'(stored);
         ring_pos = (ring_pos == RING_DEPTH - 1) ? '0 : ring_pos + 1'b1;
         wet = scale_q16(delayed, K_WET);
         r.out_left   = saturate_bus(bl + scale_q16(dl, K_DRY) + wet);
         r.out_right  = saturate_bus(br + scale_q16(dr, K_DRY) + wet);
         r.mode_taken = MODE_COMB;
      end
      return r;
   endfunction

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (reset) begin
         foreach (ring_mem[i]) ring_mem[i] = '0;
         ring_pos  = '0;
         block_cnt = '0;
         arm_reg   = 1'b0;
         buf_reg   = 1'b0;
         base_reg  = '0;
         end_reg   = '0;
         span_reg  = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_mix_q.size() == 0) begin
               $error("result item with no expectation waiting");
               mismatch_count++;
            end else begin
               want = expected_mix_q.pop_front();
               if (rsp_data.out_left !== want.out_left) begin
                  $error("out_left expected %0d actual %0d", want.out_left, rsp_data.out_left);
                  mismatch_count++;
               end
               if (rsp_data.out_right !== want.out_right) begin
                  $error("out_right expected %0d actual %0d",
                         want.out_right, rsp_data.out_right);
                  mismatch_count++;
               end
               if (rsp_data.mode_taken !== want.mode_taken) begin
                  $error("mode_taken expected %0d actual %0d",
                         want.mode_taken, rsp_data.mode_taken);
                  mismatch_count++;
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_ARM:        arm_reg  = csr_wdata[0];
               CSR_USE_BUFFER: buf_reg  = csr_wdata[0];
               CSR_DESC_BASE:  base_reg = csr_wdata;
               CSR_DESC_END:   end_reg  = csr_wdata;
               CSR_DESC_SPAN:  span_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_mix_q.push_back(mix_sample(req_data));
      end
   end

   // The receiver stalls on a rotating pattern, redrawn once it has been stepped
   // through, unless a long hold has been requested.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (pat_step == 0) begin
         case (stall_level)
            0:       stall_pat = '0;
            1:       stall_pat = $urandom & $urandom & $urandom;
            2:       stall_pat = $urandom & $urandom;
            default: stall_pat = $urandom;
         endcase
      end
      pat_step = (pat_step + 1) % 32;
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= stall_pat[pat_step];
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[stereo_feedback_comb_mixer] ERROR");
      $finish;
   end

   function automatic sample_type rand_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3, 4:    return sample_type'(int'($urandom_range(0, 2**20 - 1)) - 2**19);
         5, 6:    return sample_type'(int'($urandom_range(0, 2**22 - 1)) - 2**21);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic req_type make_item(bit start);
      req_type it;
      it.block_start = start;
      it.dry_left    = rand_sample();
      it.dry_right   = rand_sample();
      it.bus_left    = rand_sample();
      it.bus_right   = rand_sample();
      return it;
   endfunction

   task automatic pick_descriptor(output logic [31:0] b, output logic [31:0] e,
                                  output logic [31:0] s);
      logic [31:0] bytes;
      case ($urandom_range(0, 5))
         0:       bytes = DESC_MIN_BYTES;
         1:       bytes = DESC_MAX_BYTES;
         default: bytes = $urandom_range(DESC_MIN_BYTES / 4, DESC_MAX_BYTES / 4) * 4;
      endcase
      if ($urandom_range(0, 3) == 0)
         s = bytes;
      else
         s = bytes + $urandom_range(0, (DESC_MAX_BYTES - bytes) / 4) * 4;
      b = $urandom_range(1, (32'hFFFF_FFFF - DESC_MAX_BYTES) / 4) * 4;
      e = b + bytes;
   endtask

   // The item stays offered until taken; valid is dropped only for a gap.
   task automatic send_sample(input req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_level == 0) ? 0 : $urandom_range(0, 4 * gap_level);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // The clock is waited on first so that the last accepted item is already queued.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_mix_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // The upper bits of the one-bit registers carry junk that must be ignored.
   task automatic program_regs(input bit arm_v, input bit buf_v, input logic [31:0] base_v,
                               input logic [31:0] end_v, input logic [31:0] span_v);
      logic [31:0] junk;
      wait_drained();
      junk = $urandom;
      write_reg(CSR_ARM, {junk[31:1], arm_v});
      junk = $urandom;
      write_reg(CSR_USE_BUFFER, {junk[31:1], buf_v});
      write_reg(CSR_DESC_BASE, base_v);
      write_reg(CSR_DESC_END, end_v);
      write_reg(CSR_DESC_SPAN, span_v);
      csr_write <= 1'b0;
      // The plausibility flag is registered behind the descriptor registers and must settle.
      repeat (2) @(posedge clock);
   endtask

   task automatic test_pass_through();
      send_sample(req_type'{1'b0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
      send_sample(req_type'{1'b1, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN});
      send_sample(req_type'{1'b0, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX});
      send_sample(make_item(1'b1));
   endtask

   task automatic test_descriptor_checks();
      logic [31:0] desc_cases [14][3] = '{
         '{32'h0000_0000, 32'h0000_0100, 32'h0000_0200},
         '{32'h0000_1000, 32'h0000_1000, 32'h0000_0200},
         '{32'h0000_1000, 32'h0000_0FF0, 32'h0000_0200},
         '{32'h0000_1002, 32'h0000_1102, 32'h0000_0200},
         '{32'h0000_1000, 32'h0000_1101, 32'h0000_0200},
         '{32'h0000_1000, 32'h0000_1100, 32'h0000_0201},
         '{32'h0000_1000, 32'h0000_105C, 32'h0000_0200},
         '{32'h0000_1000, 32'h0000_1060, 32'h0000_005C},
         '{32'h0000_1000, 32'h0080_1004, 32'h0080_0000},
         '{32'h0000_1000, 32'h0000_1100, 32'h0080_0004},
         '{32'h0000_1000, 32'h0000_1200, 32'h0000_0100},
         '{32'hFFFF_FF00, 32'hFFFF_FFFC, 32'hFFFF_FFFF},
         '{32'h0000_1000, 32'h0000_1060, 32'h0000_0060},
         '{32'h0000_0004, 32'h0080_0004, 32'h0080_0000}
      };
      foreach (desc_cases[i]) begin
         program_regs(1'b1, 1'b0, desc_cases[i][0], desc_cases[i][1], desc_cases[i][2]);
         send_sample(make_item(1'b1));
      end
      // A sound descriptor with the effect disarmed still passes straight through.
      program_regs(1'b0, 1'b1, 32'h0000_1000, 32'h0000_1100, 32'h0000_0200);
      send_sample(make_item(1'b0));
   endtask

   task automatic test_wobble_gains();
      logic [31:0] b, e, s;
      pick_descriptor(b, e, s);
      program_regs(1'b1, 1'b0, b, e, s);
      send_sample(req_type'{1'b1, SAMPLE_MAX, SAMPLE_MAX, '0, '0});
      send_sample(req_type'{1'b1, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN});
      send_sample(req_type'{1'b0, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN});
   endtask

   task automatic test_comb_ring();
      logic [31:0] b, e, s;
      pick_descriptor(b, e, s);
      program_regs(1'b1, 1'b1, b, e, s);
      send_sample(req_type'{1'b0, SAMPLE_MAX, SAMPLE_MAX, '0, '0});
      send_sample(req_type'{1'b0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN});
      send_sample(req_type'{1'b1, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX});
      send_sample(make_item(1'b0));
   endtask

   // The output is held off while the sender keeps going, so the input backs up;
   // then the sender waits for every result before going on.
   task automatic test_backpressure();
      logic [31:0] b, e, s;
      pick_descriptor(b, e, s);
      program_regs(1'b1, 1'b1, b, e, s);
      gap_level   = 0;
      stall_level = 0;
      hold_request = LONG_HOLD;
      for (int i = 0; i < 40; i++) send_sample(make_item(i % 8 == 0));
      wait_drained();
      gap_level   = 1;
      stall_level = 2;
      for (int i = 0; i < 20; i++) send_sample(make_item(i % 8 == 0));
   endtask

   task automatic test_random_mix(input int n_items);
      int          sent, phase_len, mode, flip_bit;
      bit          arm_v, buf_v, structured;
      logic [31:0] b, e, s;
      sent = 0;
      while (sent < n_items) begin
         mode = $urandom_range(0, 19);
         pick_descriptor(b, e, s);
         if (mode < 2) begin
            // One flipped bit may or may not leave the descriptor plausible.
            flip_bit = $urandom_range(0, 31);
            case ($urandom_range(0, 2))
               0:       b[flip_bit] = ~b[flip_bit];
               1:       e[flip_bit] = ~e[flip_bit];
               default: s[flip_bit] = ~s[flip_bit];
            endcase
         end else if (mode == 2) begin
            b = $urandom;
            e = $urandom;
            s = $urandom;
         end
         arm_v = (mode < 3 || mode > 4);
         buf_v = (mode >= 12) || (mode < 3 && $urandom_range(0, 1) == 1);
         program_regs(arm_v, buf_v, b, e, s);
         gap_level   = $urandom_range(0, 3);
         stall_level = $urandom_range(0, 3);
         phase_len   = $urandom_range(20, 70);
         structured  = $urandom_range(0, 3) != 0;
         for (int i = 0; i < phase_len; i++)
            send_sample(make_item(structured ? (i % 8 == 0) : 1'($urandom_range(0, 1))));
         sent += phase_len;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_pass_through();
      test_descriptor_checks();
      test_wobble_gains();
      test_comb_ring();
      test_backpressure();
      test_random_mix(RANDOM_ITEMS);
      wait_drained();
      repeat (6) @(posedge clock);
      if (expected_mix_q.size() != 0) begin
         $error("%0d expected result items never arrived", expected_mix_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("[stereo_feedback_comb_mixer] OK");
      else
         $display("[stereo_feedback_comb_mixer] ERROR");
      $finish;
   end

endmodule

// ===== stereo_feedback_comb_mixer.f =====
+incdir+hdl
hdl/sfcm_pkg.sv
hdl/sfcm_core.sv
hdl/stereo_feedback_comb_mixer.sv
verif/tb_stereo_feedback_comb_mixer.sv
